// ----- src/hkse_pkg.sv -----
package hkse_pkg;

  localparam int HKSE_NUM_BUCKETS = 1024;
  localparam int HKSE_BUCKET_WAYS = 8;

  localparam int KEY_W     = 32;
  localparam int TSIZE_W   = 11;
  localparam int BUCKET_W  = 10;
  localparam int DIV_CNT_W = 5;

  localparam logic [TSIZE_W-1:0] TSIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_DELETE = 2'd2
  } hkse_func_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } hkse_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } hkse_state_e;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div_step;
    logic scan_rd;
    logic commit;
  } hkse_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic way_last;
    logic out_free;
  } hkse_sts_t;

endpackage

// ----- src/hkse_ram.sv -----
module hkse_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hkse_ctrl.sv -----
module hkse_ctrl import hkse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hkse_sts_t sts_i,
  output hkse_cmd_t cmd_o
);

  hkse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.way_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/hkse_dp.sv -----
module hkse_dp import hkse_pkg::*; #(
  parameter int NUM_BUCKETS = HKSE_NUM_BUCKETS,
  parameter int BUCKET_WAYS = HKSE_BUCKET_WAYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkse_cmd_t           cmd_i,
  output hkse_sts_t           sts_o,
  input  logic                cfg_we_i,
  input  logic [TSIZE_W-1:0]  cfg_data_i,
  input  logic [1:0]          func_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [BUCKET_W-1:0] bucket_o
);

  localparam int ENTRIES = NUM_BUCKETS * BUCKET_WAYS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int WORD_W  = KEY_W + 1;

  logic [TSIZE_W-1:0]   tsize_q;
  logic [TSIZE_W-1:0]   tsize_eff;
  logic [ADDR_W-1:0]    clr_cnt_q;
  logic [1:0]           func_q;
  logic [KEY_W-1:0]     key_q;
  logic [KEY_W-1:0]     dvd_q;
  logic [TSIZE_W-1:0]   dvs_q;
  logic [TSIZE_W-1:0]   rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [TSIZE_W:0]     trial;
  logic [TSIZE_W:0]     trial_sub;
  logic [WAY_W-1:0]     way_q;
  logic [WAY_W-1:0]     rd_way_q;
  logic                 rd_pend_q;
  logic                 hit_q;
  logic                 free_q;
  logic [WAY_W-1:0]     hit_way_q;
  logic [WAY_W-1:0]     free_way_q;
  logic [IDX_W-1:0]     bucket_idx;
  logic [ADDR_W-1:0]    base_addr;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_W-1:0]    wdata;
  logic [WORD_W-1:0]    rdata;
  logic                 we;
  logic                 is_insert;
  logic                 is_delete;
  logic [1:0]           status_d;
  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic                 found_q;
  logic [BUCKET_W-1:0]  bucket_q;

  // zero means one bucket, anything above the table means all of it
  always_comb begin
    tsize_eff = tsize_q;
    if (tsize_q == '0) begin
      tsize_eff = TSIZE_W'(1);
    end else if (int'(tsize_q) > NUM_BUCKETS) begin
      tsize_eff = TSIZE_W'(NUM_BUCKETS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= TSIZE_RST;
    end else if (cfg_we_i) begin
      tsize_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial     = {rem_q, dvd_q[KEY_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_i;
      // magnitude; the most negative key wraps to 2^31 unsigned
      dvd_q  <= key_i[KEY_W-1] ? (~key_i + KEY_W'(1)) : key_i;
      dvs_q  <= tsize_eff;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= trial_sub[TSIZE_W-1:0];
      end else begin
        rem_q <= trial[TSIZE_W-1:0];
      end
    end
  end

  assign bucket_idx = IDX_W'(rem_q);
  assign base_addr  = ADDR_W'(bucket_idx) * ADDR_W'(BUCKET_WAYS);
  assign raddr      = base_addr + ADDR_W'(way_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_way_q  <= '0;
    end else begin
      rd_pend_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        way_q <= '0;
      end else if (cmd_i.scan_rd) begin
        way_q    <= way_q + WAY_W'(1);
        rd_way_q <= way_q;
      end
    end
  end

  // match and first free way, evaluated as read data returns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_way_q  <= '0;
      free_way_q <= '0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (rd_pend_q) begin
      if (rdata[KEY_W]) begin
        if (!hit_q && rdata[KEY_W-1:0] == key_q) begin
          hit_q     <= 1'b1;
          hit_way_q <= rd_way_q;
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_way_q <= rd_way_q;
      end
    end
  end

  assign is_insert = (func_q == FN_INSERT);
  assign is_delete = (func_q == FN_DELETE);

  always_comb begin
    we    = 1'b0;
    waddr = base_addr + ADDR_W'(is_insert ? free_way_q : hit_way_q);
    wdata = {1'b1, key_q};
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.commit) begin
      if (is_insert) begin
        we = !hit_q && free_q;
      end else if (is_delete) begin
        we    = hit_q;
        wdata = {1'b0, key_q};
      end
    end
  end

  always_comb begin
    if (is_insert) begin
      if (hit_q) status_d = ST_DUPLICATE;
      else if (!free_q) status_d = ST_FULL;
      else status_d = ST_DONE;
    end else begin
      status_d = hit_q ? ST_DONE : ST_NOT_FOUND;
    end
  end

  hkse_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      found_q  <= hit_q;
      bucket_q <= rem_q[BUCKET_W-1:0];
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == ADDR_W'(ENTRIES - 1));
  assign sts_o.div_last = (div_cnt_q == DIV_CNT_W'(KEY_W - 1));
  assign sts_o.way_last = (way_q == WAY_W'(BUCKET_WAYS - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign bucket_o    = bucket_q;

endmodule

// ----- src/hashed_key_set_engine.sv -----
// hashed key set engine: insert, search or delete of signed 32-bit keys
// input channel: in_valid_i / in_stall_o with func_i (0 insert, 1 search,
// 2 delete, 3 acts as search) and key_i
// output channel: out_valid_o / out_stall_i with status_o (0 done,
// 1 duplicate, 2 not found, 3 bucket full), found_o and bucket_o
// table_size is written through cfg_we_i / cfg_data_i; the user must write
// it only while the block is idle, which the block itself does not enforce
// one item at a time: bit-serial modulo, then one way per cycle to scan the
// bucket (BUCKET_WAYS reads from the one key ram port), a drain step and a
// commit step; the next item is taken only after the commit
// after reset the ram is swept clear, one entry a cycle, through all
// NUM_BUCKETS * BUCKET_WAYS entries, with in_stall_o high the whole time;
// table_size resets to 1024
// the result sits in an output register; a stalled result holds while the
// next item is taken and worked, and only its commit waits for the slot
module hashed_key_set_engine import hkse_pkg::*; #(
  parameter int NUM_BUCKETS = HKSE_NUM_BUCKETS,
  parameter int BUCKET_WAYS = HKSE_BUCKET_WAYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TSIZE_W-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic signed [31:0]  key_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [BUCKET_W-1:0] bucket_o
);

  hkse_cmd_t cmd;
  hkse_sts_t sts;

  hkse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hkse_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_WAYS (BUCKET_WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .found_o     (found_o),
    .bucket_o    (bucket_o)
  );

endmodule
